@@ rtl/fpc_pkg.sv @@
// fpc_pkg: types, constants and status codes for the fletcher packet checker
// no dependencies; imported by the interfaces and every rtl module
`timescale 1ns / 1ps

package fpc_pkg;

    // packet layout
    localparam int PKT_LEN      = 14;
    localparam int PAYLOAD_LEN  = 10;
    localparam int POS_W        = 4;
    localparam int PAY_IDX_W    = $clog2(PAYLOAD_LEN);

    localparam logic [POS_W-1:0] POS_MAGIC_HI = 4'd0;
    localparam logic [POS_W-1:0] POS_MAGIC_LO = 4'd1;
    localparam logic [POS_W-1:0] POS_PAY_LO   = 4'd2;
    localparam logic [POS_W-1:0] POS_CHECK_HI = 4'd12;
    localparam logic [POS_W-1:0] POS_CHECK_LO = 4'd13;
    localparam logic [POS_W-1:0] POS_IDLE     = 4'd14;

    // fletcher modulus
    localparam logic [8:0] FL_MOD = 9'd255;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] word_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_MAGIC = 2'd1,
        STATUS_BAD_SUM   = 2'd2
    } fpc_status_t;

    // one received byte as held in the input stage
    typedef struct packed {
        byte_t rx_byte;
        logic  first_byte;
    } fpc_item_t;

    // add two values below 255 and reduce modulo 255
    function automatic byte_t add_mod255(input byte_t x, input byte_t y);
        logic [8:0] s;
        logic [8:0] r;
        begin
            s = {1'b0, x} + {1'b0, y};
            r = (s >= FL_MOD) ? (s - FL_MOD) : s;
            return r[7:0];
        end
    endfunction

endpackage

@@ rtl/fpc_if.sv @@
// fpc_if: valid/ready channel interfaces for byte input, result output and config
// depends on fpc_pkg
`timescale 1ns / 1ps

interface fpc_byte_if;
    import fpc_pkg::*;

    logic  valid;
    logic  ready;
    byte_t rx_byte;
    logic  first_byte;

    modport source (output valid, output rx_byte, output first_byte, input ready);
    modport sink   (input valid, input rx_byte, input first_byte, output ready);
endinterface

interface fpc_res_if;
    import fpc_pkg::*;

    logic        valid;
    logic        ready;
    fpc_status_t status;
    word_t       joy1_x;
    word_t       joy1_y;
    word_t       joy2_x;
    word_t       joy2_y;
    byte_t       joy1_switch;
    byte_t       joy2_switch;

    modport source (output valid, output status, output joy1_x, output joy1_y,
                    output joy2_x, output joy2_y, output joy1_switch,
                    output joy2_switch, input ready);
    modport sink   (input valid, input status, input joy1_x, input joy1_y,
                    input joy2_x, input joy2_y, input joy1_switch,
                    input joy2_switch, output ready);
endinterface

interface fpc_cfg_if;
    import fpc_pkg::*;

    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/fletcher_packet_checker.sv @@
// fletcher_packet_checker: the result of byte 13 is presented after its transaction passes
// the input register, then the state and result register.
// throughput is one byte per cycle while no result waits, set by the combinational running sum update;
// a waiting result only stalls input once the input register is also full.
// reset clears position, sums, magic flag, magic word and valid flags;
// payload bytes and result data are not reset.
`timescale 1ns / 1ps

module fletcher_packet_checker (
    input  logic       clk,
    input  logic       rst_n,
    fpc_byte_if.sink   rx,
    fpc_cfg_if.sink    cfg,
    fpc_res_if.source  res
);
    import fpc_pkg::*;

    logic      item_valid;
    fpc_item_t item;
    logic      advance;

    // input register
    fpc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // checksum core and result register
    fpc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .cfg        (cfg),
        .res        (res)
    );

    // input never stalls while the result side accepts
    assert property (@(posedge clk) disable iff (!rst_n) res.ready |-> rx.ready)
        else $error("input stalled while result side ready");

    // a new result only follows a byte taken by the core
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(item_valid && advance))
        else $error("result appeared without a processed byte");

    // failed packets carry zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.status != STATUS_OK)) |->
        (res.joy1_x == 16'd0 && res.joy1_y == 16'd0 && res.joy2_x == 16'd0 &&
         res.joy2_y == 16'd0 && res.joy1_switch == 8'd0 && res.joy2_switch == 8'd0))
        else $error("nonzero data on failed packet");

endmodule

@@ rtl/fpc_in_stage.sv @@
// fpc_in_stage: input register that holds one received byte for the core
// depends on fpc_pkg and fpc_byte_if
`timescale 1ns / 1ps

module fpc_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    fpc_byte_if.sink          rx,
    input  logic              advance,
    output logic              item_valid,
    output fpc_pkg::fpc_item_t item
);
    import fpc_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    fpc_item_t item_reg;
    logic      take;

    // stage is free when empty or being drained by the core
    assign rx.ready = !valid_reg || advance;
    assign take     = rx.valid && rx.ready;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // byte payload, loaded on each input transaction
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.rx_byte    <= rx.rx_byte;
            item_reg.first_byte <= rx.first_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ rtl/fpc_core.sv @@
// fpc_core: packet position, running fletcher sums, payload store and result register
// depends on fpc_pkg, fpc_res_if and fpc_cfg_if
`timescale 1ns / 1ps

module fpc_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  fpc_pkg::fpc_item_t item,
    output logic               advance,
    fpc_cfg_if.sink            cfg,
    fpc_res_if.source          res
);
    import fpc_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    byte_t            sum_a_reg, sum_a_next;
    byte_t            sum_b_reg, sum_b_next;
    byte_t            held_first_reg, held_first_next;
    byte_t            held_check_reg, held_check_next;
    logic             magic_ok_reg, magic_ok_next;
    word_t            magic_reg;
    byte_t            payload_reg [PAYLOAD_LEN];

    logic             res_valid_reg, res_valid_next;
    fpc_status_t      status_reg, status_next;
    word_t            joy1_x_reg, joy1_y_reg, joy2_x_reg, joy2_y_reg;
    word_t            joy1_x_next, joy1_y_next, joy2_x_next, joy2_y_next;
    byte_t            sw1_reg, sw2_reg, sw1_next, sw2_next;

    logic             fire;
    logic [POS_W-1:0] pos_eff;
    byte_t            sa_eff, sb_eff;
    logic             mok_eff;
    byte_t            sa_new, sb_new;
    logic             pay_we;
    logic [POS_W-1:0] pay_off;
    logic             emit;

    // core moves when the result register is free or being taken
    assign advance = !res_valid_reg || res.ready;
    assign fire    = item_valid && advance;

    // config port is always open
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg <= '0;
        end
        else if (cfg.valid)
        begin
            magic_reg <= cfg.data;
        end
    end

    // state as seen by this byte, after a restart flag
    assign pos_eff = item.first_byte ? POS_MAGIC_HI : pos_reg;
    assign sa_eff  = item.first_byte ? 8'd0 : sum_a_reg;
    assign sb_eff  = item.first_byte ? 8'd0 : sum_b_reg;
    assign mok_eff = item.first_byte ? 1'b0 : magic_ok_reg;

    // running sums, reduced after every byte
    assign sa_new  = add_mod255(sa_eff, item.rx_byte);
    assign sb_new  = add_mod255(sb_eff, sa_new);

    assign pay_off = pos_eff - POS_PAY_LO;
    assign pay_we  = fire && (pos_eff >= POS_PAY_LO) && (pos_eff < POS_CHECK_HI);
    assign emit    = fire && (pos_eff == POS_CHECK_LO);

    // packet state update
    always_comb
    begin
        pos_next        = pos_reg;
        sum_a_next      = sum_a_reg;
        sum_b_next      = sum_b_reg;
        held_first_next = held_first_reg;
        held_check_next = held_check_reg;
        magic_ok_next   = magic_ok_reg;
        if (fire)
        begin
            sum_a_next    = sa_eff;
            sum_b_next    = sb_eff;
            magic_ok_next = mok_eff;
            pos_next      = pos_eff;
            if (pos_eff < POS_CHECK_HI)
            begin
                sum_a_next = sa_new;
                sum_b_next = sb_new;
            end
            if (pos_eff == POS_MAGIC_HI)
            begin
                held_first_next = item.rx_byte;
            end
            if (pos_eff == POS_MAGIC_LO)
            begin
                magic_ok_next = ({held_first_reg, item.rx_byte} == magic_reg);
            end
            if (pos_eff == POS_CHECK_HI)
            begin
                held_check_next = item.rx_byte;
            end
            priority if (pos_eff < POS_CHECK_LO)
            begin
                pos_next = pos_eff + 4'd1;
            end
            else
            begin
                pos_next = POS_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            sum_a_reg      <= '0;
            sum_b_reg      <= '0;
            held_first_reg <= '0;
            held_check_reg <= '0;
            magic_ok_reg   <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            sum_a_reg      <= sum_a_next;
            sum_b_reg      <= sum_b_next;
            held_first_reg <= held_first_next;
            held_check_reg <= held_check_next;
            magic_ok_reg   <= magic_ok_next;
        end
    end

    // payload store for bytes 2 to 11
    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            payload_reg[pay_off[PAY_IDX_W-1:0]] <= item.rx_byte;
        end
    end

    // result decode on the last byte
    always_comb
    begin
        status_next = STATUS_OK;
        joy1_x_next = '0;
        joy1_y_next = '0;
        joy2_x_next = '0;
        joy2_y_next = '0;
        sw1_next    = '0;
        sw2_next    = '0;
        priority if (!magic_ok_reg)
        begin
            status_next = STATUS_BAD_MAGIC;
        end
        else if ((held_check_reg != sum_b_reg) || (item.rx_byte != sum_a_reg))
        begin
            status_next = STATUS_BAD_SUM;
        end
        else
        begin
            joy1_x_next = {payload_reg[0], payload_reg[1]};
            joy1_y_next = {payload_reg[2], payload_reg[3]};
            joy2_x_next = {payload_reg[4], payload_reg[5]};
            joy2_y_next = {payload_reg[6], payload_reg[7]};
            sw1_next    = payload_reg[8];
            sw2_next    = payload_reg[9];
        end
    end

    always_comb
    begin
        if (emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg <= status_next;
            joy1_x_reg <= joy1_x_next;
            joy1_y_reg <= joy1_y_next;
            joy2_x_reg <= joy2_x_next;
            joy2_y_reg <= joy2_y_next;
            sw1_reg    <= sw1_next;
            sw2_reg    <= sw2_next;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.status      = status_reg;
    assign res.joy1_x      = joy1_x_reg;
    assign res.joy1_y      = joy1_y_reg;
    assign res.joy2_x      = joy2_x_reg;
    assign res.joy2_y      = joy2_y_reg;
    assign res.joy1_switch = sw1_reg;
    assign res.joy2_switch = sw2_reg;

endmodule
